// File: rtl/pnldd_pkg.sv
// ----------------------------------------------------------------------------
// pnldd_pkg
// Shared types, constants and saturation helpers of the PnL/drawdown tracker.
// ----------------------------------------------------------------------------
package pnldd_pkg;

	// Fraction bits of the signed PnL values (48.16 by default, 8 to 24).
	localparam int FRACTION_BITS = 16;
	localparam int FRACTION_MAX  = 24;

	// The commission arrives as 16.16 and is aligned to FRACTION_BITS.
	localparam int COST_SHL = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
	localparam int COST_SHR = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
	localparam int COST_W   = 64 + FRACTION_MAX - 16;

	localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CMUL,
		ST_CCOST,
		ST_MUL,
		ST_DINIT,
		ST_DIV,
		ST_OFIN,
		ST_SCALE,
		ST_CADD,
		ST_CSUB,
		ST_CFIN,
		ST_MLOAD,
		ST_MEQ,
		ST_MPEAK,
		ST_MDD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PATH_OPEN,
		PATH_CLOSE,
		PATH_MARK
	} path_t;

	// True when a 128-bit two's complement value fits in 64 bits.
	function automatic logic fits64(input logic [127:0] x);
		return (&x[127:63]) | ~(|x[127:63]);
	endfunction

	function automatic logic [63:0] sat64(input logic [127:0] x);
		logic [63:0] r;
		if (fits64(x)) begin
			r = x[63:0];
		end else if (x[127]) begin
			r = NEG_MIN;
		end else begin
			r = POS_MAX;
		end
		return r;
	endfunction

endpackage

// File: rtl/position_pnl_drawdown_tracker_top.sv
// ----------------------------------------------------------------------------
// position_pnl_drawdown_tracker_top
// Average-cost position, realized/unrealized PnL and drawdown tracker.
// ----------------------------------------------------------------------------
// Each input word carries one optional fill and one optional mark price. The
// block holds one word at a time: in_ready is high only while the sequencer is
// idle. The time a word takes depends on its fill, if any, and on whether its
// mark is valid, plus any time spent waiting for a previous result to leave.
// It is set by the single shared 32x32 multiplier, which forms the commission
// product in one piece and every other product as a series of partial products
// into a 128-bit accumulator, and by the radix-2 divider that finds one
// quotient bit per cycle of the new average price. A finished result sits in
// an output register, so the next word is accepted and worked on while the
// previous result still waits for out_ready. PnL values are signed with
// FRACTION_BITS fraction bits and saturate; overflow_flag marks a word during
// which any value saturated.
// ----------------------------------------------------------------------------
module position_pnl_drawdown_tracker_top
	import pnldd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               fill_side,
	input  logic [31:0]        fill_price,
	input  logic [31:0]        fill_quantity,
	input  logic [31:0]        commission_per_unit,
	input  logic [31:0]        mark_price,
	input  logic               mark_valid,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] position_quantity,
	output logic [31:0]        average_price,
	output logic signed [63:0] realized_profit,
	output logic signed [63:0] unrealized_profit,
	output logic [62:0]        deepest_drawdown,
	output logic               overflow_flag
);

	state_t state_q, state_d;
	path_t  path_q;
	logic [1:0] k_q, nmul_q;
	logic [4:0] cnt_q;
	logic       out_valid_q;

	// Architectural state.
	logic [63:0] pos_q, realized_q, peak_q;
	logic [31:0] entry_q;
	logic [62:0] worst_q;

	// Captured input word.
	logic        side_q, markok_q;
	logic [31:0] price_q, qty_q, comm_q, mark_q;

	// Working registers.
	logic [31:0]       op_a_q;
	logic [63:0]       op_b_q, div_q, rem_q, eq_q, unreal_q, prod_q;
	logic              prod_hi_q, dneg_q, was_long_q, ovf_q;
	logic [127:0]      acc_q;
	logic [COST_W-1:0] cost_q;

	// Result register.
	logic [63:0] o_pos_q, o_real_q, o_unreal_q;
	logic [31:0] o_avg_q;
	logic [62:0] o_dd_q;
	logic        o_ovf_q;

	logic [31:0] mul_a, mul_b;
	logic        mul_hi;
	logic [63:0] prod_d;

	logic        accept;
	logic [63:0] mag_w, qty64;
	logic        opening_w;
	logic [32:0] cdiff_w, mdiff_w;
	logic [63:0] closed_w;
	logic [64:0] div_trial, div_sub;
	logic        div_ge;
	logic [127:0] eqsum_w;
	logic [63:0] dd_w;

	assign accept   = in_valid && in_ready;
	assign qty64    = {32'd0, qty_q};
	assign mag_w    = pos_q[63] ? (64'd0 - pos_q) : pos_q;
	// A fill opens when it is on the side of the position or the position is flat.
	assign opening_w = (!side_q && !pos_q[63]) || (side_q && (pos_q[63] || pos_q == 64'd0));
	assign cdiff_w  = !pos_q[63] ? ({1'b0, price_q} - {1'b0, entry_q})
	                             : ({1'b0, entry_q} - {1'b0, price_q});
	assign mdiff_w  = !pos_q[63] ? ({1'b0, mark_q} - {1'b0, entry_q})
	                             : ({1'b0, entry_q} - {1'b0, mark_q});
	assign closed_w = (qty64 >= mag_w) ? mag_w : qty64;

	// One restoring divider step: the quotient bits enter acc_q[31:0] from the right.
	assign div_trial = {rem_q, acc_q[31]};
	assign div_ge    = div_trial >= {1'b0, div_q};
	assign div_sub   = div_trial - {1'b0, div_q};

	assign eqsum_w = acc_q + {{64{realized_q[63]}}, realized_q};
	assign dd_w    = peak_q - eq_q;

	// Shared multiplier operand selection.
	always_comb begin
		mul_a  = op_a_q;
		mul_b  = op_b_q[31:0];
		mul_hi = 1'b0;
		unique case (state_q)
			ST_CMUL: begin
				mul_a = comm_q;
				mul_b = qty_q;
			end
			ST_MUL: begin
				unique case (k_q)
					2'd1: begin
						mul_b  = op_b_q[63:32];
						mul_hi = 1'b1;
					end
					2'd2: begin
						mul_a = price_q;
						mul_b = qty_q;
					end
					default: mul_b = op_b_q[31:0];
				endcase
			end
			default: mul_b = op_b_q[31:0];
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_LOAD;
			ST_LOAD: begin
				if (qty_q == 32'd0) begin
					state_d = ST_MLOAD;
				end else if (opening_w) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_CMUL;
				end
			end
			ST_CMUL:  state_d = ST_CCOST;
			ST_CCOST: state_d = ST_MUL;
			ST_MUL: begin
				if (k_q == nmul_q) begin
					state_d = (path_q == PATH_OPEN) ? ST_DINIT : ST_SCALE;
				end
			end
			ST_DINIT: state_d = ST_DIV;
			ST_DIV:   if (cnt_q == 5'd31) state_d = ST_OFIN;
			ST_OFIN:  state_d = ST_MLOAD;
			ST_SCALE: state_d = (path_q == PATH_CLOSE) ? ST_CADD : ST_MEQ;
			ST_CADD:  state_d = ST_CSUB;
			ST_CSUB:  state_d = ST_CFIN;
			ST_CFIN:  state_d = ST_MLOAD;
			ST_MLOAD: begin
				if (!markok_q) begin
					state_d = ST_OUT;
				end else if (pos_q == 64'd0) begin
					state_d = ST_MEQ;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MEQ:   state_d = ST_MPEAK;
			ST_MPEAK: state_d = ST_MDD;
			ST_MDD:   state_d = ST_OUT;
			ST_OUT:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = out_valid_q;
	end

	assign position_quantity = o_pos_q;
	assign average_price     = o_avg_q;
	assign realized_profit   = o_real_q;
	assign unrealized_profit = o_unreal_q;
	assign deepest_drawdown  = o_dd_q;
	assign overflow_flag     = o_ovf_q;

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			path_q      <= PATH_OPEN;
			k_q         <= 2'd0;
			nmul_q      <= 2'd0;
			cnt_q       <= 5'd0;
			out_valid_q <= 1'b0;
			pos_q       <= 64'd0;
			entry_q     <= 32'd0;
			realized_q  <= 64'd0;
			peak_q      <= 64'd0;
			worst_q     <= 63'd0;
		end else begin
			state_q <= state_d;
			// A new result replaces the one leaving in the same cycle.
			if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					k_q <= 2'd0;
					if (opening_w) begin
						path_q <= PATH_OPEN;
						nmul_q <= 2'd3;
					end else begin
						path_q <= PATH_CLOSE;
						nmul_q <= 2'd2;
					end
				end
				ST_MUL:   k_q <= k_q + 2'd1;
				ST_DINIT: cnt_q <= 5'd0;
				ST_DIV:   cnt_q <= cnt_q + 5'd1;
				ST_OFIN: begin
					entry_q <= acc_q[31:0];
					if (div_q[63]) begin
						pos_q <= side_q ? (64'd0 - POS_MAX) : POS_MAX;
					end else begin
						pos_q <= side_q ? (64'd0 - div_q) : div_q;
					end
				end
				ST_CFIN: begin
					realized_q <= sat64(acc_q);
					if (qty64 >= mag_w) begin
						pos_q <= was_long_q ? (mag_w - qty64) : (qty64 - mag_w);
						if (qty64 != mag_w) entry_q <= price_q;
					end else begin
						pos_q <= was_long_q ? (mag_w - qty64) : (qty64 - mag_w);
					end
				end
				ST_MLOAD: begin
					path_q <= PATH_MARK;
					k_q    <= 2'd0;
					nmul_q <= 2'd2;
				end
				ST_MPEAK: if ($signed(eq_q) > $signed(peak_q)) peak_q <= eq_q;
				ST_MDD: begin
					if (dd_w[63]) begin
						worst_q <= POS_MAX[62:0];
					end else if (dd_w[62:0] > worst_q) begin
						worst_q <= dd_w[62:0];
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath working registers.
	always_ff @(posedge clk) begin
		prod_q    <= prod_d;
		prod_hi_q <= mul_hi;
		if (accept) begin
			side_q   <= fill_side;
			price_q  <= fill_price;
			qty_q    <= fill_quantity;
			comm_q   <= commission_per_unit;
			mark_q   <= mark_price;
			markok_q <= mark_valid;
			ovf_q    <= 1'b0;
			unreal_q <= 64'd0;
		end
		unique case (state_q)
			ST_LOAD: begin
				acc_q      <= 128'd0;
				was_long_q <= !pos_q[63];
				if (opening_w) begin
					op_a_q <= entry_q;
					op_b_q <= mag_w;
					div_q  <= mag_w + qty64;
				end else begin
					dneg_q <= cdiff_w[32];
					op_a_q <= cdiff_w[32] ? 32'(33'd0 - cdiff_w) : cdiff_w[31:0];
					op_b_q <= closed_w;
				end
			end
			ST_CCOST: begin
				cost_q <= ({{(COST_W - 64){1'b0}}, prod_q} << COST_SHL) >> COST_SHR;
			end
			ST_MUL: begin
				if (k_q != 2'd0) begin
					acc_q <= acc_q + (prod_hi_q ? {32'd0, prod_q, 32'd0} : {64'd0, prod_q});
				end
			end
			ST_DINIT: rem_q <= acc_q[95:32];
			ST_DIV: begin
				rem_q        <= div_ge ? div_sub[63:0] : div_trial[63:0];
				acc_q[31:0]  <= {acc_q[30:0], div_ge};
			end
			ST_OFIN:  if (div_q[63]) ovf_q <= 1'b1;
			ST_SCALE: begin
				acc_q <= dneg_q ? (128'd0 - (acc_q << FRACTION_BITS))
				                : (acc_q << FRACTION_BITS);
			end
			ST_CADD:  acc_q <= acc_q + {{64{realized_q[63]}}, realized_q};
			ST_CSUB:  acc_q <= acc_q - {{(128 - COST_W){1'b0}}, cost_q};
			ST_CFIN:  if (!fits64(acc_q)) ovf_q <= 1'b1;
			ST_MLOAD: begin
				acc_q  <= 128'd0;
				dneg_q <= mdiff_w[32];
				op_a_q <= mdiff_w[32] ? 32'(33'd0 - mdiff_w) : mdiff_w[31:0];
				op_b_q <= mag_w;
			end
			ST_MEQ: begin
				unreal_q <= sat64(acc_q);
				eq_q     <= sat64(eqsum_w);
				if (!fits64(acc_q) || !fits64(eqsum_w)) ovf_q <= 1'b1;
			end
			ST_MDD:   if (dd_w[63]) ovf_q <= 1'b1;
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					o_pos_q    <= pos_q;
					o_avg_q    <= entry_q;
					o_real_q   <= realized_q;
					o_unreal_q <= unreal_q;
					o_dd_q     <= worst_q;
					o_ovf_q    <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	// The sequencer takes no new word until the current one is finished.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("in_ready high right after an accepted word");

	// The divider remainder always stays below the divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < div_q))
		else $error("divider remainder not below divisor");

	// After the peak update the equity never lies above the peak.
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MDD) |-> ($signed(peak_q) >= $signed(eq_q)))
		else $error("equity above peak equity");

	// The position never reaches the most negative value.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != NEG_MIN)
		else $error("net position left its saturation range");

endmodule

// File: bench/position_pnl_drawdown_tracker_top_tb.sv
// ----------------------------------------------------------------------------
// position_pnl_drawdown_tracker_top_tb
// Self-checking bench for the average-cost position and drawdown tracker.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of position, average price, realized
// PnL, peak equity and worst drawdown, and works out the result of every
// accepted word. Each result that leaves the block is compared field by field
// with the oldest prediction. Directed words hit the price and quantity
// extremes, saturation and every fill path; random words then trade around a
// drifting price with some full-range noise mixed in, under random idling on
// both sides and a long receiver stall.
// ----------------------------------------------------------------------------
module position_pnl_drawdown_tracker_top_tb
	import pnldd_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [127:0] WIDE_HI = 128'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [127:0] WIDE_LO = -128'sh8000_0000_0000_0000;
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef struct packed {
		logic signed [63:0] pos;
		logic [31:0]        avg;
		logic signed [63:0] rlz;
		logic signed [63:0] unreal;
		logic [62:0]        dd;
		logic               ovf;
	} pnl_result_t;

	// The scoreboard holds the tracker state as the block should see it.
	class pnl_scoreboard;
		logic signed [63:0] net_pos;
		logic [31:0]        avg_px;
		logic signed [63:0] realized;
		logic signed [63:0] peak;
		logic [62:0]        worst_dd;
		pnl_result_t        expected_q[$];
		int                 mismatches;
		int                 results_seen;

		function new();
			net_pos = 0;
			avg_px = 0;
			realized = 0;
			peak = 0;
			worst_dd = 0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic signed [63:0] clamp64(input logic signed [127:0] x, inout bit ovf);
			if (x > WIDE_HI) begin
				ovf = 1;
				return POS_MAX;
			end
			if (x < WIDE_LO) begin
				ovf = 1;
				return NEG_MIN;
			end
			return x[63:0];
		endfunction

		function void note_input(input logic side, input logic [31:0] price,
				input logic [31:0] qty, input logic [31:0] comm,
				input logic [31:0] mark, input logic mvalid);
			logic [63:0]         mag, newmag, closed, rest;
			logic [64:0]         sum_mag;
			logic [127:0]        total;
			logic signed [127:0] acc, open_pnl, cost, diff;
			logic signed [63:0]  equity;
			logic signed [64:0]  dd;
			bit                  ovf, was_long;
			pnl_result_t         r;
			ovf = 0;
			r.unreal = 0;
			mag = (net_pos < 0) ? -net_pos : net_pos;
			if (qty != 0) begin
				if ((side == 1'b0 && net_pos >= 0) || (side == 1'b1 && net_pos <= 0)) begin
					// Adding to the position: fold the fill into the average.
					sum_mag = {1'b0, mag} + {33'd0, qty};
					total = 128'(avg_px) * 128'(mag) + 128'(price) * 128'(qty);
					avg_px = 32'(total / 128'(sum_mag));
					newmag = sum_mag[63:0];
					if (newmag > POS_MAX) begin
						newmag = POS_MAX;
						ovf = 1;
					end
					net_pos = side ? -$signed(newmag) : $signed(newmag);
				end else begin
					// Reducing the position: realize against the average price.
					was_long = net_pos > 0;
					closed = (qty >= mag) ? mag : {32'd0, qty};
					diff = $signed({96'd0, price}) - $signed({96'd0, avg_px});
					if (!was_long)
						diff = -diff;
					cost = $signed({64'd0, 64'(comm) * 64'(qty)});
					if (FRACTION_BITS >= 16)
						cost = cost << (FRACTION_BITS - 16);
					else
						cost = cost >> (16 - FRACTION_BITS);
					acc = realized + ((diff * $signed({64'd0, closed})) <<< FRACTION_BITS)
						- cost;
					realized = clamp64(acc, ovf);
					if (qty >= mag) begin
						// Through zero the remainder lands on the other side.
						rest = qty - mag;
						net_pos = was_long ? -$signed(rest) : $signed(rest);
						if (rest != 0)
							avg_px = price;
					end else begin
						rest = mag - qty;
						net_pos = was_long ? $signed(rest) : -$signed(rest);
					end
				end
			end
			if (mvalid) begin
				open_pnl = 0;
				if (net_pos != 0) begin
					mag = (net_pos < 0) ? -net_pos : net_pos;
					diff = $signed({96'd0, mark}) - $signed({96'd0, avg_px});
					if (net_pos < 0)
						diff = -diff;
					open_pnl = (diff * $signed({64'd0, mag})) <<< FRACTION_BITS;
				end
				r.unreal = clamp64(open_pnl, ovf);
				equity = clamp64(realized + open_pnl, ovf);
				if (equity > peak)
					peak = equity;
				dd = $signed({peak[63], peak}) - $signed({equity[63], equity});
				if (dd > $signed({1'b0, POS_MAX})) begin
					dd = {1'b0, POS_MAX};
					ovf = 1;
				end
				if (dd[62:0] > worst_dd)
					worst_dd = dd[62:0];
			end
			r.pos = net_pos;
			r.avg = avg_px;
			r.rlz = realized;
			r.dd = worst_dd;
			r.ovf = ovf;
			expected_q = {expected_q, r};
		endfunction

		function void report(input string field, input logic [63:0] exp_v,
				input logic [63:0] act_v);
			if (exp_v !== act_v) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch on result %0d, %s: expected %h, got %h",
						results_seen, field, exp_v, act_v);
			end
		endfunction

		function void check_result(input pnl_result_t act);
			pnl_result_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result word with no prediction waiting");
				return;
			end
			e = expected_q.pop_front();
			report("position_quantity", e.pos, act.pos);
			report("average_price", 64'(e.avg), 64'(act.avg));
			report("realized_profit", e.rlz, act.rlz);
			report("unrealized_profit", e.unreal, act.unreal);
			report("deepest_drawdown", 64'(e.dd), 64'(act.dd));
			report("overflow_flag", 64'(e.ovf), 64'(act.ovf));
			results_seen++;
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               fill_side;
	logic [31:0]        fill_price;
	logic [31:0]        fill_quantity;
	logic [31:0]        commission_per_unit;
	logic [31:0]        mark_price;
	logic               mark_valid;
	logic               out_valid;
	logic               out_ready;
	logic signed [63:0] position_quantity;
	logic [31:0]        average_price;
	logic signed [63:0] realized_profit;
	logic signed [63:0] unrealized_profit;
	logic [62:0]        deepest_drawdown;
	logic               overflow_flag;

	pnl_scoreboard sb = new();
	int  cycles;
	int  words_sent;
	bit  hold_request;

	position_pnl_drawdown_tracker_top u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.fill_side          (fill_side),
		.fill_price         (fill_price),
		.fill_quantity      (fill_quantity),
		.commission_per_unit(commission_per_unit),
		.mark_price         (mark_price),
		.mark_valid         (mark_valid),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.position_quantity  (position_quantity),
		.average_price      (average_price),
		.realized_profit    (realized_profit),
		.unrealized_profit  (unrealized_profit),
		.deepest_drawdown   (deepest_drawdown),
		.overflow_flag      (overflow_flag)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Both monitors read the values that were present just before the edge, so
	// the order in which processes wake at the edge does not matter.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_input(fill_side, fill_price, fill_quantity, commission_per_unit,
				mark_price, mark_valid);
		if (arst_n && out_valid && out_ready)
			sb.check_result({position_quantity, average_price, realized_profit,
				unrealized_profit, deepest_drawdown, overflow_flag});
	end

	// The run is cut off if it hangs; a hang counts as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Mostly no idling, sometimes a short gap and now and then a long one.
	function automatic int gap_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// The receiver idles at random. When asked, it holds off for a long
	// stretch so that the output register fills and the block stops taking
	// words while the sender keeps offering them.
	initial begin
		out_ready = 1'b0;
		hold_request = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_request = 0;
			end else if (gap_length() > 0) begin
				out_ready <= 1'b0;
				repeat (gap_length()) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(0, 8)) @(posedge clk);
			end
		end
	end

	// Offers one word and returns at the edge that accepted it, leaving valid
	// high so a following word can go out back to back.
	task automatic send_word(input logic side, input logic [31:0] price,
			input logic [31:0] qty, input logic [31:0] comm,
			input logic [31:0] mark, input logic mvalid);
		in_valid <= 1'b1;
		fill_side <= side;
		fill_price <= price;
		fill_quantity <= qty;
		commission_per_unit <= comm;
		mark_price <= mark;
		mark_valid <= mvalid;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic sender_gap(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	initial begin
		logic [31:0] base_px, px, mk;
		int          roll;
		arst_n = 1'b0;
		in_valid = 1'b0;
		fill_side = 1'b0;
		fill_price = '0;
		fill_quantity = '0;
		commission_per_unit = '0;
		mark_price = '0;
		mark_valid = 1'b0;
		cycles = 0;
		words_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed words. Nothing at all, then a mark while flat.
		send_word(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
		send_word(1'b1, 32'd5, 32'd0, 32'd9, 32'hFFFF_FFFF, 1'b1);
		// Open long from flat, add more, mark below entry so equity drops from
		// the start and counts as drawdown.
		send_word(1'b0, 32'd1000, 32'd10, 32'd0, 32'd1000, 1'b1);
		send_word(1'b0, 32'd1003, 32'd7, 32'd0, 32'd990, 1'b1);
		// Partial close with commission, then a close landing exactly flat,
		// which keeps the average price.
		send_word(1'b1, 32'd1010, 32'd5, 32'h0001_8000, 32'd1005, 1'b1);
		send_word(1'b1, 32'd995, 32'd12, 32'h0000_4000, 32'd1, 1'b1);
		// Open short from flat, then buy through zero: the rest opens long at
		// the fill price.
		send_word(1'b1, 32'd2000, 32'd30, 32'd0, 32'd2100, 1'b1);
		send_word(1'b0, 32'd1900, 32'd50, 32'd65536, 32'd1950, 1'b0);
		// Mark-only with an invalid mark leaves peak and drawdown alone.
		send_word(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
		// A fill with an invalid mark that sells through zero, then a sell that adds to the short.
		send_word(1'b1, 32'd1850, 32'd40, 32'd100, 32'd1850, 1'b0);
		send_word(1'b1, 32'd1800, 32'd30, 32'd0, 32'd0, 1'b1);
		// Extreme prices and quantities: equity and realized PnL saturate.
		send_word(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1);
		send_word(1'b1, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_word(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_word(1'b0, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 1'b1);
		send_word(1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
		send_word(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_word(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
		send_word(1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
		send_word(1'b0, 32'd1, 32'd1, 32'd1, 32'd1, 1'b1);

		// Random words. Most trade around a slowly drifting price so the
		// position builds, closes and flips; some are full-range noise.
		hold_request = 1;
		base_px = 32'd100000;
		for (int i = 0; i < 1100; i++) begin
			if (i == 550) begin
				// Let the block drain completely before going on.
				sender_gap(1);
				while (sb.pending() > 0)
					@(posedge clk);
			end
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				send_word(1'($urandom), $urandom, $urandom, $urandom, $urandom,
					1'($urandom));
			end else begin
				base_px = base_px + $urandom_range(0, 400) - 200;
				px = base_px + $urandom_range(0, 2000) - 1000;
				mk = base_px + $urandom_range(0, 2000) - 1000;
				send_word(1'($urandom), px,
					(roll < 23) ? 32'd0 : 32'($urandom_range(1, 500)),
					$urandom_range(0, 3 * 65536), mk, $urandom_range(0, 4) != 0);
			end
			sender_gap(gap_length());
		end
		in_valid <= 1'b0;

		while (sb.pending() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("Checked %0d results from %0d words: fills opening, closing, landing flat",
			sb.results_seen, words_sent);
		$display("and reversing, mark-only words, saturation, under random stalls on both sides.");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches, %0d predictions left over", sb.mismatches,
				sb.pending());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: position_pnl_drawdown_tracker_top.f
rtl/pnldd_pkg.sv
rtl/position_pnl_drawdown_tracker_top.sv
bench/position_pnl_drawdown_tracker_top_tb.sv
